// ----- hdl/mdm_pkg.sv -----
// ============================================================================
// Mecanum drive mixer package
// Widths, direction codes, pipeline types and the speed curve table shared
// by the mixer pipeline.
// ============================================================================
package mdm_pkg;

    // Field widths.
    localparam int STICK_W  = 8;
    localparam int MP_W     = 7;
    localparam int SPD_W    = 7;
    localparam int DIR_W    = 2;

    // Internal widths: wheel powers span -384..383, magnitudes up to 384.
    localparam int POW_W    = 10;
    localparam int MAG_W    = 9;
    localparam int DEN_W    = 10;
    localparam int QUO_W    = 8;
    localparam int NUM_W    = 18;
    localparam int QIDX_W   = $clog2(QUO_W);

    localparam int WHEELS   = 4;

    // Wheel slots in the result word.
    localparam int WHEEL_FL = 0;
    localparam int WHEEL_BL = 1;
    localparam int WHEEL_FR = 2;
    localparam int WHEEL_BR = 3;

    // Divider layout: two quotient bits are resolved in every stage.
    localparam int DIV_BITS   = 2;
    localparam int DIV_STAGES = QUO_W / DIV_BITS;

    // Cycles from the accepting edge to the edge that takes the result.
    localparam int PIPE_LAT   = DIV_STAGES + 6;

    // Stick and power conversion constants.
    localparam int STICK_CENTER = 128;
    localparam int DEAD_LO      = -2;
    localparam int DEAD_HI      = 2;
    localparam int FWD_OFFSET   = 3;
    localparam int BWD_OFFSET   = 2;
    localparam int POWER_SPAN   = 125;
    localparam int BYTE_SPAN    = 255;
    localparam int SPEED_MAX    = 127;

    localparam logic [MP_W-1:0] MP_RESET = MP_W'(127);

    // Motor direction codes.
    localparam logic [DIR_W-1:0] DIR_RELEASE  = 2'd0;
    localparam logic [DIR_W-1:0] DIR_FORWARD  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_BACKWARD = 2'd2;

    typedef logic signed [POW_W-1:0] t_power;
    typedef logic [NUM_W-1:0]        t_num;
    typedef logic [QUO_W-1:0]        t_quo;

    // One word moving through the divider stages.
    typedef struct packed {
        logic                  scale;
        logic [MP_W-1:0]       mp;
        logic [DEN_W-1:0]      den;
        t_power [WHEELS-1:0]   pw;
        t_num   [WHEELS-1:0]   rem;
        t_quo   [WHEELS-1:0]   quo;
    } t_div_stage;

    // Speed curve: offset power 0..125 to motor speed, two chained maps.
    localparam int SPEED_LUT_DEPTH = 2 ** SPD_W;
    typedef logic [SPEED_LUT_DEPTH-1:0][SPD_W-1:0] t_speed_lut;

    function automatic t_speed_lut build_speed_lut();
        t_speed_lut lut;
        int         t;
        for (int i = 0; i < SPEED_LUT_DEPTH; i++) begin
            t = (i * BYTE_SPAN) / POWER_SPAN;
            if (t > BYTE_SPAN) begin
                t = BYTE_SPAN;
            end
            lut[i] = SPD_W'((t * SPEED_MAX) / BYTE_SPAN);
        end
        return lut;
    endfunction

    localparam t_speed_lut SPEED_LUT = build_speed_lut();

endpackage

// ----- hdl/mecanum_drive_mixer.sv -----
// ============================================================================
// Mecanum drive mixer
// Mixes three stick bytes into four wheel powers, rescales them when they
// exceed the power limit, and turns each into a motor speed and direction.
// ============================================================================
// Usage:
// A command word (axial, lateral, yaw stick bytes) is taken at a rising edge
// with start high and busy low. busy stays low: the pipeline takes one word
// in every cycle.
// Each result appears on the o_ ports for one cycle with o_valid high.
// Throughput is one word per clock.
// Latency is set by the input register, mixer, peak search, numerator
// multiply, the four stage divider (two quotient bits a stage) for the
// proportional rescale, the power select and the speed table stage.
// The power limit is written on the cfg channel, which is always ready; the
// value is captured with each word as it enters, so words already in flight
// keep the limit they entered with.
// A synchronous low reset empties the pipeline and sets the limit to 127.
// The receiver cannot stall, so no buffering beyond the output register.
module mecanum_drive_mixer (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [mdm_pkg::STICK_W-1:0] i_axial_stick,
    input  logic [mdm_pkg::STICK_W-1:0] i_lateral_stick,
    input  logic [mdm_pkg::STICK_W-1:0] i_yaw_stick,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [mdm_pkg::MP_W-1:0]    i_cfg_data,
    output logic                        o_valid,
    output logic [mdm_pkg::SPD_W-1:0]   o_front_left_speed,
    output logic [mdm_pkg::DIR_W-1:0]   o_front_left_dir,
    output logic [mdm_pkg::SPD_W-1:0]   o_back_left_speed,
    output logic [mdm_pkg::DIR_W-1:0]   o_back_left_dir,
    output logic [mdm_pkg::SPD_W-1:0]   o_front_right_speed,
    output logic [mdm_pkg::DIR_W-1:0]   o_front_right_dir,
    output logic [mdm_pkg::SPD_W-1:0]   o_back_right_speed,
    output logic [mdm_pkg::DIR_W-1:0]   o_back_right_dir
);
    import mdm_pkg::*;

    logic accept;

    // Limit register.
    logic [MP_W-1:0] r_max_power;

    // Stage 1: captured stick bytes.
    logic                r_s1_vld;
    logic [STICK_W-1:0]  r_s1_axial;
    logic [STICK_W-1:0]  r_s1_lateral;
    logic [STICK_W-1:0]  r_s1_yaw;
    logic [MP_W-1:0]     r_s1_mp;

    // Stage 2: mixed wheel powers.
    logic                r_s2_vld;
    t_power [WHEELS-1:0] r_s2_pw;
    logic [MP_W-1:0]     r_s2_mp;
    t_power [WHEELS-1:0] n_s2_pw;

    // Stage 3: peak magnitude and rescale decision.
    logic                r_s3_vld;
    t_power [WHEELS-1:0] r_s3_pw;
    logic [MP_W-1:0]     r_s3_mp;
    logic [MAG_W-1:0]    r_s3_mag;
    logic                r_s3_scale;
    logic [MAG_W-1:0]    n_s3_mag;

    // Divider stages.
    logic [DIV_STAGES:0] r_div_vld;
    t_div_stage          r_div [0:DIV_STAGES];
    t_div_stage          n_div_head;
    t_div_stage          n_div [0:DIV_STAGES-1];

    // Final power stage.
    logic                r_p_vld;
    t_power [WHEELS-1:0] r_p_pw;
    t_power [WHEELS-1:0] n_p_pw;

    // Output register.
    logic                         r_out_vld;
    logic [WHEELS-1:0][SPD_W-1:0] r_speed;
    logic [WHEELS-1:0][DIR_W-1:0] r_dir;
    logic [WHEELS-1:0][SPD_W-1:0] n_speed;
    logic [WHEELS-1:0][DIR_W-1:0] n_dir;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    // Limit register, to be written between commands by the user; the block itself does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_power <= MP_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_power <= i_cfg_data;
        end
    end

    // Mix: remove the stick offset and form the four wheel sums.
    always_comb begin
        t_power a;
        t_power l;
        t_power y;
        a = t_power'(r_s1_axial) - t_power'(STICK_CENTER);
        l = t_power'(r_s1_lateral) - t_power'(STICK_CENTER);
        y = t_power'(r_s1_yaw) - t_power'(STICK_CENTER);
        n_s2_pw[WHEEL_FL] = a - l - y;
        n_s2_pw[WHEEL_BL] = a + l - y;
        n_s2_pw[WHEEL_FR] = a + l + y;
        n_s2_pw[WHEEL_BR] = a - l + y;
    end

    // Peak search over the four magnitudes as a two-level compare tree.
    always_comb begin
        logic [WHEELS-1:0][MAG_W-1:0] mag;
        logic [MAG_W-1:0]             m01;
        logic [MAG_W-1:0]             m23;
        for (int w = 0; w < WHEELS; w++) begin
            if (r_s2_pw[w] < 0) begin
                mag[w] = MAG_W'(-r_s2_pw[w]);
            end else begin
                mag[w] = MAG_W'(r_s2_pw[w]);
            end
        end
        m01      = (mag[0] > mag[1]) ? mag[0] : mag[1];
        m23      = (mag[2] > mag[3]) ? mag[2] : mag[3];
        n_s3_mag = (m01 > m23) ? m01 : m23;
    end

    // Rescale numerator (x + m) * (2 * limit + 1) and denominator 2 * m.
    always_comb begin
        logic signed [POW_W:0] sum;
        logic [DEN_W-1:0]      xm;
        logic [MP_W:0]         span;
        span             = {r_s3_mp, 1'b1};
        n_div_head.scale = r_s3_scale;
        n_div_head.mp    = r_s3_mp;
        n_div_head.den   = {r_s3_mag, 1'b0};
        n_div_head.pw    = r_s3_pw;
        for (int w = 0; w < WHEELS; w++) begin
            sum                = {r_s3_pw[w][POW_W-1], r_s3_pw[w]}
                               + $signed({2'b00, r_s3_mag});
            xm                 = sum[DEN_W-1:0];
            n_div_head.rem[w]  = t_num'(xm) * t_num'(span);
            n_div_head.quo[w]  = '0;
        end
    end

    // Restoring division, two quotient bits per stage. The quotient never
    // exceeds 2 * limit + 1, so eight bits cover it.
    always_comb begin
        t_num              trial;
        logic [QIDX_W-1:0] k;
        for (int s = 0; s < DIV_STAGES; s++) begin
            n_div[s] = r_div[s];
            for (int w = 0; w < WHEELS; w++) begin
                for (int j = 0; j < DIV_BITS; j++) begin
                    k     = QIDX_W'(QUO_W - 1 - (s * DIV_BITS + j));
                    trial = t_num'(r_div[s].den) << k;
                    if (n_div[s].rem[w] >= trial) begin
                        n_div[s].rem[w]    = n_div[s].rem[w] - trial;
                        n_div[s].quo[w][k] = 1'b1;
                    end
                end
            end
        end
    end

    // Pick the rescaled power or the mixed power.
    always_comb begin
        t_power q;
        for (int w = 0; w < WHEELS; w++) begin
            q = t_power'(r_div[DIV_STAGES].quo[w]);
            if (r_div[DIV_STAGES].scale) begin
                n_p_pw[w] = q - t_power'(r_div[DIV_STAGES].mp) - t_power'(1);
            end else begin
                n_p_pw[w] = r_div[DIV_STAGES].pw[w];
            end
        end
    end

    // Power to speed and direction through the speed curve table.
    always_comb begin
        t_power off;
        for (int w = 0; w < WHEELS; w++) begin
            if (r_p_pw[w] < t_power'(DEAD_LO)) begin
                off        = -r_p_pw[w] - t_power'(FWD_OFFSET);
                n_speed[w] = SPEED_LUT[off[SPD_W-1:0]];
                n_dir[w]   = DIR_FORWARD;
            end else if (r_p_pw[w] >= t_power'(DEAD_HI)) begin
                off        = r_p_pw[w] - t_power'(BWD_OFFSET);
                n_speed[w] = SPEED_LUT[off[SPD_W-1:0]];
                n_dir[w]   = DIR_BACKWARD;
            end else begin
                off        = '0;
                n_speed[w] = '0;
                n_dir[w]   = DIR_RELEASE;
            end
        end
    end

    // Valid bits travel with the words.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_div_vld <= '0;
            r_p_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= accept;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_div_vld <= {r_div_vld[DIV_STAGES-1:0], r_s3_vld};
            r_p_vld   <= r_div_vld[DIV_STAGES];
            r_out_vld <= r_p_vld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_axial   <= i_axial_stick;
            r_s1_lateral <= i_lateral_stick;
            r_s1_yaw     <= i_yaw_stick;
            r_s1_mp      <= r_max_power;
        end
        r_s2_pw    <= n_s2_pw;
        r_s2_mp    <= r_s1_mp;
        r_s3_pw    <= r_s2_pw;
        r_s3_mp    <= r_s2_mp;
        r_s3_mag   <= n_s3_mag;
        r_s3_scale <= n_s3_mag > MAG_W'(r_s2_mp);
        r_div[0]   <= n_div_head;
        for (int s = 0; s < DIV_STAGES; s++) begin
            r_div[s+1] <= n_div[s];
        end
        r_p_pw  <= n_p_pw;
        r_speed <= n_speed;
        r_dir   <= n_dir;
    end

    assign o_valid             = r_out_vld;
    assign o_front_left_speed  = r_speed[WHEEL_FL];
    assign o_front_left_dir    = r_dir[WHEEL_FL];
    assign o_back_left_speed   = r_speed[WHEEL_BL];
    assign o_back_left_dir     = r_dir[WHEEL_BL];
    assign o_front_right_speed = r_speed[WHEEL_FR];
    assign o_front_right_dir   = r_dir[WHEEL_FR];
    assign o_back_right_speed  = r_speed[WHEEL_BR];
    assign o_back_right_dir    = r_dir[WHEEL_BR];

    // Every result comes from a command taken a fixed latency earlier.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(accept, PIPE_LAT))
        else $error("result without matching command");

    // A released wheel never carries a speed.
    a_release_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |->
            (o_front_left_dir  != DIR_RELEASE || o_front_left_speed  == '0) &&
            (o_back_left_dir   != DIR_RELEASE || o_back_left_speed   == '0) &&
            (o_front_right_dir != DIR_RELEASE || o_front_right_speed == '0) &&
            (o_back_right_dir  != DIR_RELEASE || o_back_right_speed  == '0))
        else $error("released wheel with nonzero speed");

    // A rescaled front-left or front-right power lands inside the limit span, so its quotient fits.
    a_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_vld[DIV_STAGES] && r_div[DIV_STAGES].scale |->
            r_div[DIV_STAGES].quo[WHEEL_FL] <= QUO_W'({r_div[DIV_STAGES].mp, 1'b1}) &&
            r_div[DIV_STAGES].quo[WHEEL_FR] <= QUO_W'({r_div[DIV_STAGES].mp, 1'b1}))
        else $error("rescale quotient out of range");

endmodule
